/* sv/sha_pkg.sv */
// Package with SHA-256 constants, round table and round functions.
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlockB  = 64;
  localparam int unsigned LenPos  = 56;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* sv/sha256_stream_hasher_core.sv */
// SHA-256 streaming hasher: byte buffer, padding sequencer and round unit.
// Bytes are taken one per cycle while the 64-byte block fills. When a block
// completes, one shared round unit runs the 64 rounds, one per cycle, then the
// ST_ADD state adds into the chain; the input stalls meanwhile. On an
// item with tlast the block pads (0x80, zeros, 64-bit bit count) through the
// byte buffer one byte per cycle, runs one or two more compressions, and then
// presents the eight digest words; the input is not ready until the last word
// is taken. The message schedule is a 16-word shift window. After reset the
// block is ready at once.
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  state_t      state;
  logic [5:0]  fill;        // bytes in the buffer
  logic [63:0] msg_bits;
  logic        pad_done;    // 0x80 already written
  logic        final_blk;   // running compression carries the length
  logic        last_pend;   // end mark came with the transaction that completed this block
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  word_t       chain [8];
  word_t       v [8];
  word_t       w [16];      // buffer words, reused as schedule window

  word_t t1, t2, w_new, w_cur;
  logic  accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'd0, out_idx, chain[out_idx]};
  assign m_tlast  = (out_idx == 3'd7);

  // Round datapath
  always_comb begin
    w_cur = w[0];
    w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + w_cur;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Write one byte into its word slot of the buffer
  function automatic void put_byte(ref word_t wb [16], input logic [5:0] pos,
                                   input logic [7:0] b);
    logic [3:0] wi;
    logic [1:0] bi;
    wi = pos[5:2];
    bi = pos[1:0];
    case (bi)
      2'd0:    wb[wi][31:24] = b;
      2'd1:    wb[wi][23:16] = b;
      2'd2:    wb[wi][15:8]  = b;
      default: wb[wi][7:0]   = b;
    endcase
  endfunction

  // Sequencer, buffer, round unit and chain
  always_ff @(posedge clk) begin
    word_t wtmp [16];
    logic [7:0] pb;
    wtmp = w;
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg_bits  <= '0;
      pad_done  <= 1'b0;
      final_blk <= 1'b0;
      last_pend <= 1'b0;
      rnd       <= '0;
      out_idx   <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= InitChain[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              put_byte(wtmp, fill, s_tdata);
              w        <= wtmp;
              msg_bits <= msg_bits + 64'd8;
              fill     <= fill + 6'd1;
            end
            // start compression on a full block, else pad if last
            if (s_tuser && fill == 6'(BlockB - 1)) begin
              state <= ST_ROUND;
              rnd   <= '0;
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
            pad_done  <= 1'b0;
            final_blk <= 1'b0;
            last_pend <= s_tlast;
          end
        end
        ST_PAD: begin
          // one padding byte per cycle
          if (!pad_done) pb = PadByte;
          else if (final_blk) pb = msg_bits[8*(7 - (fill - 6'(LenPos)))+:8];
          else pb = 8'd0;
          put_byte(wtmp, fill, pb);
          w        <= wtmp;
          pad_done <= 1'b1;
          fill     <= fill + 6'd1;
          if (fill == 6'(BlockB - 1)) begin
            state <= ST_ROUND;
            rnd   <= '0;
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
          end
          // enter the length area after byte 55
          if (!final_blk && (fill + 6'd1) == 6'(LenPos))
            final_blk <= 1'b1;
        end
        ST_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          if (final_blk) begin
            state   <= ST_OUT;
            out_idx <= '0;
          end else if (pad_done || last_pend) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state    <= ST_IDLE;
              fill     <= '0;
              msg_bits <= '0;
              pad_done <= 1'b0;
              final_blk <= 1'b0;
              last_pend <= 1'b0;
              for (int i = 0; i < 8; i++) chain[i] <= InitChain[i];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
